[design/ctb_pkg.sv]
package ctb_pkg;

	// Default build of the bank
	localparam int CTB_TIMER_COUNT  = 16;
	localparam int CTB_TICKS_PER_MS = 1;

	// Fixed unit ratios
	localparam int CTB_MS_PER_TENTH       = 100;
	localparam int CTB_TENTHS_PER_SECOND  = 10;
	localparam int CTB_SECONDS_PER_MINUTE = 60;

	// Field widths
	localparam int CTB_MAX_TIMERS = 16;
	localparam int CTB_VALUE_W    = 16;
	localparam int CTB_TICKS_W    = 32;
	localparam int CTB_UNIT_W     = 2;

	typedef enum logic [2:0] {
		CMD_TICK    = 3'd0,
		CMD_START   = 3'd1,
		CMD_STOP    = 3'd2,
		CMD_PAUSE   = 3'd3,
		CMD_GET     = 3'd4,
		CMD_SET     = 3'd5,
		CMD_COLLECT = 3'd6,
		CMD_NOP     = 3'd7
	} ctb_cmd_t;

	typedef enum logic [1:0] {
		ST_OK          = 2'd0,
		ST_BAD_INDEX   = 2'd1,
		ST_BAD_BASE    = 2'd2,
		ST_NOT_RUNNING = 2'd3
	} ctb_status_t;

	typedef enum logic [1:0] {
		UNIT_MS     = 2'd0,
		UNIT_TENTH  = 2'd1,
		UNIT_SECOND = 2'd2,
		UNIT_MINUTE = 2'd3
	} ctb_unit_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_MUL,
		S_WRITE,
		S_DIV,
		S_SWEEP,
		S_DONE
	} ctb_state_t;

	typedef struct packed {
		ctb_cmd_t                 cmd;
		logic [3:0]               timer_index;
		logic [CTB_VALUE_W-1:0]   value;
		logic [2:0]               time_base;
		logic                     pause_mode;
	} ctb_in_t;

	typedef struct packed {
		ctb_status_t              status;
		logic [CTB_VALUE_W-1:0]   value_out;
		logic [CTB_MAX_TIMERS-1:0] expired_mask;
	} ctb_out_t;

endpackage

[design/ctb_ram.sv]
module ctb_ram #(
	parameter int WIDTH = 34,
	parameter int DEPTH = 16
) (
	input  logic                  clk,
	input  logic                  we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]      wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]      rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[design/countdown_timer_bank.sv]
// State sequence: stop, pause, collect, unused codes and rejected commands go from exec to done;
// start and set go through exec, multiply, write and done; get goes through exec, divide and done
// (reciprocal multiply in two halves); tick sweeps the timer memory, one timer read-modify-write
// per cycle, then goes to done. One command at a time; the next is taken in the cycle after the
// result moves to the output register.
// Reset clears flags, per-entry valid bits and handshakes at once; no clearing pass is needed,
// an entry not yet written reads as a stopped timer.
module countdown_timer_bank
	import ctb_pkg::*;
#(
	parameter int TIMER_COUNT  = CTB_TIMER_COUNT,
	parameter int TICKS_PER_MS = CTB_TICKS_PER_MS
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     cmd_valid,
	output logic     cmd_ready,
	input  ctb_in_t  cmd_data,
	output logic     rsp_valid,
	input  logic     rsp_ready,
	output ctb_out_t rsp_data
);

	localparam int AW = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
	localparam int CW = $clog2(TIMER_COUNT + 1);
	localparam longint U_MS     = TICKS_PER_MS;
	localparam longint U_TENTH  = U_MS * CTB_MS_PER_TENTH;
	localparam longint U_SECOND = U_TENTH * CTB_TENTHS_PER_SECOND;
	localparam longint U_MINUTE = U_SECOND * CTB_SECONDS_PER_MINUTE;
	localparam int UW = $clog2(U_MINUTE + 1);
	localparam int PW = (CTB_VALUE_W + UW > CTB_TICKS_W) ? CTB_VALUE_W + UW : CTB_TICKS_W + 1;
	localparam int EW = CTB_UNIT_W + CTB_TICKS_W;

	// Reciprocal constants: quotient = (ticks * M) >> (32 + L), exact for 32-bit ticks
	localparam int MW  = CTB_TICKS_W + 1;
	localparam int PPW = CTB_VALUE_W + MW;
	localparam int QW  = CTB_TICKS_W + MW;
	localparam int L_MS     = $clog2(U_MS);
	localparam int L_TENTH  = $clog2(U_TENTH);
	localparam int L_SECOND = $clog2(U_SECOND);
	localparam int L_MINUTE = $clog2(U_MINUTE);
	localparam longint M_MS     = ((longint'(1) << (CTB_TICKS_W + L_MS)) + U_MS - 1) / U_MS;
	localparam longint M_TENTH  =
		((longint'(1) << (CTB_TICKS_W + L_TENTH)) + U_TENTH - 1) / U_TENTH;
	localparam longint M_SECOND =
		((longint'(1) << (CTB_TICKS_W + L_SECOND)) + U_SECOND - 1) / U_SECOND;
	localparam longint M_MINUTE =
		((longint'(1) << (CTB_TICKS_W + L_MINUTE)) + U_MINUTE - 1) / U_MINUTE;

	// Tick count of one unit
	function automatic logic [UW-1:0] unit_ticks(input ctb_unit_t u);
		logic [UW-1:0] r;
		unique case (u)
			UNIT_MS:     r = UW'(U_MS);
			UNIT_TENTH:  r = UW'(U_TENTH);
			UNIT_SECOND: r = UW'(U_SECOND);
			UNIT_MINUTE: r = UW'(U_MINUTE);
			default:     r = UW'(U_MS);
		endcase
		return r;
	endfunction

	// Reciprocal multiplier of one unit
	function automatic logic [MW-1:0] recip(input ctb_unit_t u);
		logic [MW-1:0] r;
		unique case (u)
			UNIT_MS:     r = MW'(M_MS);
			UNIT_TENTH:  r = MW'(M_TENTH);
			UNIT_SECOND: r = MW'(M_SECOND);
			UNIT_MINUTE: r = MW'(M_MINUTE);
			default:     r = MW'(M_MS);
		endcase
		return r;
	endfunction

	// Quotient from the full reciprocal product
	function automatic logic [CTB_TICKS_W-1:0] recip_quo(input logic [QW-1:0] p,
			input ctb_unit_t u);
		logic [CTB_TICKS_W-1:0] r;
		unique case (u)
			UNIT_MS:     r = CTB_TICKS_W'(p >> (CTB_TICKS_W + L_MS));
			UNIT_TENTH:  r = CTB_TICKS_W'(p >> (CTB_TICKS_W + L_TENTH));
			UNIT_SECOND: r = CTB_TICKS_W'(p >> (CTB_TICKS_W + L_SECOND));
			UNIT_MINUTE: r = CTB_TICKS_W'(p >> (CTB_TICKS_W + L_MINUTE));
			default:     r = CTB_TICKS_W'(p >> (CTB_TICKS_W + L_MS));
		endcase
		return r;
	endfunction

	ctb_state_t state_q, state_d;
	ctb_in_t    item_q;

	logic [TIMER_COUNT-1:0] valid_q;
	logic [TIMER_COUNT-1:0] pend_q;
	logic [TIMER_COUNT-1:0] pause_q;

	logic          vld_s1;
	logic          sw_vld_s1;
	logic [AW-1:0] sw_idx_s1;
	logic [CW-1:0] cnt_q;

	ctb_unit_t                 unit_q;
	logic [PW-1:0]             prod_q;
	logic [CTB_TICKS_W-1:0]    dvd_q;
	logic [QW-1:0]             acc_q;
	logic                      step_q;
	ctb_status_t               status_q;
	logic [CTB_MAX_TIMERS-1:0] mask_q;

	logic     rsp_valid_q;
	ctb_out_t rsp_q;

	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [EW-1:0] ram_wdata;
	logic [AW-1:0] ram_raddr;
	logic [EW-1:0] ram_rdata;

	logic [EW-1:0]          entry;
	logic [CTB_TICKS_W-1:0] e_ticks;
	ctb_unit_t              e_unit;
	logic                   idx_ok;
	logic [AW-1:0]          idx_a;
	logic                   running;
	logic                   sw_run;
	logic [CTB_TICKS_W-1:0] sat_ticks;
	logic [CTB_VALUE_W-1:0] div_half;
	logic [PPW-1:0]         pp;
	logic [CTB_TICKS_W-1:0] quo;
	logic [CTB_VALUE_W-1:0] get_val;
	logic                   ld_rsp;

	// Timer memory: {unit, remaining ticks}
	ctb_ram #(
		.WIDTH (EW),
		.DEPTH (TIMER_COUNT)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Read address: the addressed timer on a transfer, the sweep counter otherwise.
	// Writes never happen in idle, so a read never meets a write to the same entry.
	assign ram_raddr = (state_q == S_IDLE) ? cmd_data.timer_index[AW-1:0] : cnt_q[AW-1:0];

	// Entry never written reads as a stopped timer
	assign entry   = vld_s1 ? ram_rdata : '0;
	assign e_ticks = entry[CTB_TICKS_W-1:0];
	assign e_unit  = ctb_unit_t'(entry[EW-1:CTB_TICKS_W]);
	assign idx_ok  = 32'(item_q.timer_index) < TIMER_COUNT;
	assign idx_a   = item_q.timer_index[AW-1:0];
	assign running = (e_ticks != '0);
	assign sw_run  = sw_vld_s1 && running && !pause_q[sw_idx_s1];

	// Saturate the scaled duration to 32 bits
	assign sat_ticks = (|prod_q[PW-1:CTB_TICKS_W]) ? '1 : prod_q[CTB_TICKS_W-1:0];

	// Reciprocal multiply, low half of the ticks first, then the high half
	assign div_half = step_q ? dvd_q[CTB_TICKS_W-1:CTB_VALUE_W] : dvd_q[CTB_VALUE_W-1:0];
	assign pp       = PPW'(div_half) * PPW'(recip(unit_q));
	assign quo      = recip_quo(acc_q, unit_q);

	assign get_val = (|quo[CTB_TICKS_W-1:CTB_VALUE_W]) ? '1 : quo[CTB_VALUE_W-1:0];

	// Next state and memory write control
	always_comb begin
		state_d   = state_q;
		cmd_ready = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = idx_a;
		ram_wdata = '0;
		ld_rsp    = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				cmd_ready = 1'b1;
				if (cmd_valid) begin
					state_d = (cmd_data.cmd == CMD_TICK) ? S_SWEEP : S_EXEC;
				end
			end
			S_EXEC: begin
				state_d = S_DONE;
				unique case (item_q.cmd)
					CMD_START: begin
						if (idx_ok && item_q.time_base <= 3'(UNIT_MINUTE)) begin
							state_d = S_MUL;
						end
					end
					CMD_STOP: begin
						ram_we = idx_ok;
					end
					CMD_GET: begin
						if (idx_ok && running) begin
							state_d = S_DIV;
						end
					end
					CMD_SET: begin
						if (idx_ok && running) begin
							state_d = S_MUL;
						end
					end
					default: ;
				endcase
			end
			S_MUL: begin
				state_d = S_WRITE;
			end
			S_WRITE: begin
				ram_we    = 1'b1;
				ram_wdata = {unit_q, sat_ticks};
				state_d   = S_DONE;
			end
			S_DIV: begin
				if (step_q) begin
					state_d = S_DONE;
				end
			end
			S_SWEEP: begin
				if (sw_run) begin
					ram_we    = 1'b1;
					ram_waddr = sw_idx_s1;
					ram_wdata = {e_unit, e_ticks - 1'b1};
				end
				if (cnt_q == CW'(TIMER_COUNT) && !sw_vld_s1) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (!rsp_valid_q || rsp_ready) begin
					ld_rsp  = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Control state: flags, valid bits, sweep pipeline, result handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			pend_q      <= '0;
			pause_q     <= '0;
			sw_vld_s1   <= 1'b0;
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (ram_we) begin
				valid_q[ram_waddr] <= 1'b1;
			end
			sw_vld_s1 <= (state_q == S_SWEEP) && (cnt_q != CW'(TIMER_COUNT));
			if (state_q == S_IDLE) begin
				cnt_q <= '0;
			end else if (state_q == S_SWEEP && cnt_q != CW'(TIMER_COUNT)) begin
				cnt_q <= cnt_q + 1'b1;
			end
			// Expiry on the tick that brings a timer to zero
			if (state_q == S_SWEEP && sw_run && e_ticks == CTB_TICKS_W'(1)) begin
				pend_q[sw_idx_s1] <= 1'b1;
			end
			if (state_q == S_EXEC && idx_ok) begin
				if (item_q.cmd == CMD_STOP) begin
					pend_q[idx_a] <= 1'b0;
				end
				if (item_q.cmd == CMD_PAUSE) begin
					pause_q[idx_a] <= item_q.pause_mode;
				end
			end
			if (state_q == S_EXEC && item_q.cmd == CMD_COLLECT) begin
				pend_q <= '0;
			end
			if (ld_rsp) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		vld_s1    <= valid_q[ram_raddr];
		sw_idx_s1 <= cnt_q[AW-1:0];
		unique case (state_q)
			S_IDLE: begin
				if (cmd_valid) begin
					item_q   <= cmd_data;
					status_q <= ST_OK;
					mask_q   <= '0;
				end
			end
			S_EXEC: begin
				unique case (item_q.cmd)
					CMD_START: begin
						if (!idx_ok) begin
							status_q <= ST_BAD_INDEX;
						end else if (item_q.time_base > 3'(UNIT_MINUTE)) begin
							status_q <= ST_BAD_BASE;
						end
						unit_q <= ctb_unit_t'(item_q.time_base[CTB_UNIT_W-1:0]);
					end
					CMD_STOP, CMD_PAUSE: begin
						if (!idx_ok) begin
							status_q <= ST_BAD_INDEX;
						end
					end
					CMD_GET, CMD_SET: begin
						if (!idx_ok) begin
							status_q <= ST_BAD_INDEX;
						end else if (!running) begin
							status_q <= ST_NOT_RUNNING;
						end
						unit_q <= e_unit;
						dvd_q  <= e_ticks;
						step_q <= 1'b0;
					end
					CMD_COLLECT: begin
						mask_q <= CTB_MAX_TIMERS'(pend_q);
					end
					default: ;
				endcase
			end
			S_MUL: begin
				prod_q <= PW'(item_q.value) * PW'(unit_ticks(unit_q));
			end
			S_DIV: begin
				if (!step_q) begin
					acc_q <= QW'(pp);
				end else begin
					acc_q <= acc_q + (QW'(pp) << CTB_VALUE_W);
				end
				step_q <= 1'b1;
			end
			S_SWEEP: begin
				if (sw_run && e_ticks == CTB_TICKS_W'(1)) begin
					mask_q[sw_idx_s1] <= 1'b1;
				end
			end
			default: ;
		endcase
		if (ld_rsp) begin
			rsp_q.status       <= status_q;
			rsp_q.value_out    <= (item_q.cmd == CMD_GET && status_q == ST_OK) ? get_val : '0;
			rsp_q.expired_mask <= mask_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

	// Memory writes only away from idle, so reads issued on a transfer see settled data
	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> state_q != S_IDLE)
		else $error("timer memory written while idle");

	// One command in flight
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_valid && cmd_ready) |=> !cmd_ready)
		else $error("second command taken while busy");

	// Writes stay inside the bank
	a_write_range: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> 32'(ram_waddr) < TIMER_COUNT)
		else $error("timer write beyond bank");

	// Pending flags are only raised by the tick sweep
	a_pend_rise: assert property (@(posedge clk) disable iff (!arst_n)
		(|(pend_q & ~$past(pend_q))) |-> $past(state_q) == S_SWEEP)
		else $error("pending flag raised outside tick sweep");

endmodule
